// ----- rtl/psq_pkg.sv -----
// Shared constants, scale degree tables and table helpers of the pitch scale quantiser.
package psq_pkg;

	localparam int PIN_W           = 25;
	localparam int MODE_W          = 3;
	localparam int TBL_BITS        = 28;
	localparam int PSQ_FRAC_BITS   = 20;
	localparam int PSQ_MAX_DEGREES = 13;

	localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_EQ12   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_EQ7    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_JUST12 = 3'd3;
	localparam logic [MODE_W-1:0] MODE_JUST7  = 3'd4;

	// Degrees in Q28 octaves; row order follows the scale mode codes minus one.
	localparam logic [TBL_BITS:0] DEG_TBL [0:3][0:15] = '{
		'{29'd0, 29'd22369621, 29'd44739243, 29'd67108864, 29'd89478485,
		  29'd111848107, 29'd134217728, 29'd156587349, 29'd178956971,
		  29'd201326592, 29'd223696213, 29'd246065835, 29'd268435456,
		  29'd0, 29'd0, 29'd0},
		'{29'd0, 29'd44739243, 29'd89478485, 29'd111848107, 29'd156587349,
		  29'd201326592, 29'd246065835, 29'd268435456,
		  29'd0, 29'd0, 29'd0, 29'd0, 29'd0, 29'd0, 29'd0, 29'd0},
		'{29'd0, 29'd24993865, 29'd45613895, 29'd70607761, 29'd86416915,
		  29'd111410780, 29'd132030810, 29'd157024676, 29'd182018541,
		  29'd197827695, 29'd227632436, 29'd243441591, 29'd268435456,
		  29'd0, 29'd0, 29'd0},
		'{29'd0, 29'd45613895, 29'd86416915, 29'd111410780, 29'd157024676,
		  29'd197827695, 29'd243441591, 29'd268435456,
		  29'd0, 29'd0, 29'd0, 29'd0, 29'd0, 29'd0, 29'd0, 29'd0}
	};

	localparam logic [4:0] DEG_CNT [0:3] = '{5'd13, 5'd8, 5'd13, 5'd8};

	// Degree rounded to nearest at fb fraction bits, halves upward.
	function automatic logic [TBL_BITS:0] deg_at(input logic [1:0] tbl,
			input logic [3:0] idx, input int fb);
		int shift;
		logic [TBL_BITS+1:0] t;
		shift = TBL_BITS - fb;
		t = {1'b0, DEG_TBL[tbl][idx]};
		if (shift > 0) begin
			t = (t + ((TBL_BITS+2)'(1) << (shift - 1))) >> shift;
		end
		return t[TBL_BITS:0];
	endfunction

	// Number of table entries in use, capped by the degree limit.
	function automatic logic [4:0] n_used(input logic [1:0] tbl, input int maxd);
		logic [4:0] n;
		n = DEG_CNT[tbl];
		if (int'(n) > maxd) begin
			n = 5'(maxd);
		end
		return n;
	endfunction

endpackage

// ----- rtl/psq_pick.sv -----
// Nearest-degree choice between the two enclosing degrees, with the near-tie window.
module psq_pick #(
	parameter int FRAC_BITS = psq_pkg::PSQ_FRAC_BITS
) (
	input  logic [FRAC_BITS-1:0] frac,
	input  logic [FRAC_BITS:0]   lo,
	input  logic [FRAC_BITS:0]   hi,
	input  logic                 force_hi,
	output logic [FRAC_BITS:0]   deg
);
	import psq_pkg::*;

	logic [FRAC_BITS:0]   d_lo;
	logic [FRAC_BITS:0]   d_hi;
	logic [FRAC_BITS:0]   diff;
	logic [FRAC_BITS+7:0] diff_x120;
	logic                 near_tie;

	always_comb begin
		d_lo      = {1'b0, frac} - lo;
		d_hi      = hi - {1'b0, frac};
		diff      = (d_hi > d_lo) ? (d_hi - d_lo) : (d_lo - d_hi);
		// 120 * diff as 128 * diff - 8 * diff
		diff_x120 = {diff, 7'b0} - {4'b0, diff, 3'b0};
		near_tie  = (diff_x120[FRAC_BITS+7:FRAC_BITS] == 8'd0);
		if (force_hi) begin
			deg = hi;
		end else if (near_tie) begin
			deg = lo;
		end else begin
			deg = (d_hi < d_lo) ? hi : lo;
		end
	end

endmodule

// ----- rtl/pitch_scale_quantizer.sv -----
// Top level of the pitch scale quantiser: four-stage pipeline and configuration register.
//
// Snaps a 1 V/octave pitch word (signed, FRAC_BITS fraction bits) to the nearest degree of
// the scale chosen by scale_mode: 0 off (pass-through), 1 twelve-tone equal, 2 major equal,
// 3 twelve-tone just, 4 major just; codes 5 to 7 also pass through. The pitch is split into
// a floor octave and a fraction; the fraction is matched against a constant degree table,
// and when the two enclosing degrees lie within 1/120 octave of equidistant the lower one
// wins. Degree 1.0 may be chosen, so the result can reach octave plus one; a result above
// the largest signed 25-bit value saturates. One word enters per cycle in the absence of
// stalls, and the stages run in order: stage 1 compares the fraction against every degree,
// stage 2 finds the enclosing pair, stage 3 picks the nearer one, stage 4 adds the octave
// and saturates. Each stage advances whenever its successor has room, so bubbles close up
// and a stalled output word lets earlier stages keep filling. Write scale_mode only
// while the pipeline is empty; cfg_ready is always high.
module pitch_scale_quantizer #(
	parameter int FRAC_BITS   = psq_pkg::PSQ_FRAC_BITS,
	parameter int MAX_DEGREES = psq_pkg::PSQ_MAX_DEGREES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [psq_pkg::MODE_W-1:0]        scale_mode,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [psq_pkg::PIN_W-1:0]  pitch_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [psq_pkg::PIN_W-1:0]  pitch_out
);
	import psq_pkg::*;

	localparam int IDX_W = $clog2(MAX_DEGREES);
	// Internal width: holds the pitch, the full fraction and octave plus one
	localparam int IW = ((FRAC_BITS + 1 > PIN_W) ? FRAC_BITS + 1 : PIN_W) + 2;
	localparam logic signed [IW-1:0] SAT_MAX = {{(IW-PIN_W+1){1'b0}}, {(PIN_W-1){1'b1}}};
	localparam logic [IW-1:0] OCT_MASK = {{(IW-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

	logic [MODE_W-1:0] scale_mode_q;

	// Stage advance chain
	logic adv1, adv2, adv3, adv4;

	// Stage 1
	logic                     valid_s1;
	logic signed [PIN_W-1:0]  pitch_s1;
	logic                     pass_s1;
	logic [1:0]               tbl_s1;
	logic [MAX_DEGREES-1:0]   ge_s1;

	// Stage 2
	logic                     valid_s2;
	logic signed [PIN_W-1:0]  pitch_s2;
	logic                     pass_s2;
	logic [FRAC_BITS:0]       lo_s2;
	logic [FRAC_BITS:0]       hi_s2;
	logic                     force_hi_s2;

	// Stage 3
	logic                     valid_s3;
	logic signed [PIN_W-1:0]  pitch_s3;
	logic                     pass_s3;
	logic [FRAC_BITS:0]       chosen_s3;

	// Stage 4 is the output register
	logic                     valid_s4;
	logic signed [PIN_W-1:0]  pitch_s4;

	// Stage 1 inputs
	logic signed [IW-1:0]     pin_ext;
	logic [FRAC_BITS-1:0]     frac_in;
	logic                     pass_in;
	logic [1:0]               tbl_in;
	logic [4:0]               n_in;
	logic [MAX_DEGREES-1:0]   ge_in;

	// Stage 2 inputs
	logic signed [IW-1:0]     s1_ext;
	logic [FRAC_BITS-1:0]     frac_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     found_s1;
	logic [4:0]               n_s1;
	logic [FRAC_BITS:0]       hi_in2;
	logic [FRAC_BITS:0]       lo_in2;
	logic                     force_hi_in2;

	// Stage 3 inputs
	logic signed [IW-1:0]     s2_ext;
	logic [FRAC_BITS:0]       chosen_in3;

	// Stage 4 inputs
	logic signed [IW-1:0]     s3_ext;
	logic signed [IW-1:0]     sum_in4;
	logic signed [PIN_W-1:0]  pitch_in4;

	// Configuration register: take every write at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_mode_q <= MODE_OFF;
		end else if (cfg_valid) begin
			scale_mode_q <= scale_mode;
		end
	end

	// Advance a stage when it is empty or its successor moves on
	always_comb begin
		adv4 = !valid_s4 || !out_stall;
		adv3 = !valid_s3 || adv4;
		adv2 = !valid_s2 || adv3;
		adv1 = !valid_s1 || adv2;
	end

	assign in_stall = !adv1;

	// Stage 1: decode the mode and compare the fraction with every degree in use
	always_comb begin
		pin_ext = IW'(pitch_in);
		frac_in = pin_ext[FRAC_BITS-1:0];
		pass_in = !(scale_mode_q inside {[MODE_EQ12:MODE_JUST7]});
		tbl_in  = 2'(scale_mode_q - MODE_EQ12);
		n_in    = n_used(tbl_in, MAX_DEGREES);
		for (int i = 0; i < MAX_DEGREES; i++) begin
			ge_in[i] = (5'(i) < n_in) &&
				((FRAC_BITS+1)'(deg_at(tbl_in, 4'(i), FRAC_BITS)) >= {1'b0, frac_in});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			pitch_s1 <= pitch_in;
			pass_s1  <= pass_in;
			tbl_s1   <= tbl_in;
			ge_s1    <= ge_in;
		end
	end

	// Stage 2: locate the first degree at or above the fraction and fetch its neighbour
	always_comb begin
		s1_ext   = IW'(pitch_s1);
		frac_s1  = s1_ext[FRAC_BITS-1:0];
		n_s1     = n_used(tbl_s1, MAX_DEGREES);
		found_s1 = |ge_s1;
		idx_s1   = '0;
		for (int i = MAX_DEGREES - 1; i >= 0; i--) begin
			if (ge_s1[i]) begin
				idx_s1 = IDX_W'(i);
			end
		end
		if (found_s1) begin
			hi_in2 = (FRAC_BITS+1)'(deg_at(tbl_s1, 4'(idx_s1), FRAC_BITS));
		end else begin
			// Fraction above every degree in use: take the last one
			hi_in2 = (FRAC_BITS+1)'(deg_at(tbl_s1, 4'(n_s1 - 5'd1), FRAC_BITS));
		end
		lo_in2 = (FRAC_BITS+1)'(deg_at(tbl_s1, 4'(idx_s1 - IDX_W'(1)), FRAC_BITS));
		force_hi_in2 = !found_s1 || (idx_s1 == '0) || (hi_in2 == {1'b0, frac_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			pitch_s2    <= pitch_s1;
			pass_s2     <= pass_s1;
			lo_s2       <= lo_in2;
			hi_s2       <= hi_in2;
			force_hi_s2 <= force_hi_in2;
		end
	end

	// Stage 3: pick the nearer degree
	assign s2_ext = IW'(pitch_s2);

	psq_pick #(
		.FRAC_BITS(FRAC_BITS)
	) u_pick (
		.frac     (s2_ext[FRAC_BITS-1:0]),
		.lo       (lo_s2),
		.hi       (hi_s2),
		.force_hi (force_hi_s2),
		.deg      (chosen_in3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			pitch_s3  <= pitch_s2;
			pass_s3   <= pass_s2;
			chosen_s3 <= chosen_in3;
		end
	end

	// Stage 4: add the floor octave back, saturate at the top of the range, or pass the pitch through
	always_comb begin
		s3_ext  = IW'(pitch_s3);
		sum_in4 = (s3_ext & $signed(OCT_MASK)) +
			$signed({{(IW-FRAC_BITS-1){1'b0}}, chosen_s3});
		if (pass_s3) begin
			pitch_in4 = pitch_s3;
		end else if (sum_in4 > SAT_MAX) begin
			pitch_in4 = SAT_MAX[PIN_W-1:0];
		end else begin
			pitch_in4 = sum_in4[PIN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			pitch_s4 <= pitch_in4;
		end
	end

	assign out_valid = valid_s4;
	assign pitch_out = pitch_s4;

`ifndef NO_ASSERTIONS
	// Degrees are ascending, so the compare vector holds a single run of ones
	a_ge_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(ge_s1 & ~(ge_s1 << 1)))
		else $error("degree compare vector is not a single run");

	// The chosen degree never exceeds one octave
	a_deg_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (chosen_s3 <= {1'b1, {FRAC_BITS{1'b0}}}))
		else $error("chosen degree above one octave");

	// A free output must open the whole advance chain
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");
`endif

endmodule
